>>> hdl/pia_pkg.sv
// Package for the palette index assigner: sizes, payload structs, state codes.
// No dependencies; used by every module in hdl/.
`default_nettype none
package pia_pkg;

   localparam int PALETTE_DEPTH = 256;
   localparam int ADDR_W        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
   localparam int COLOR_W       = 24;
   localparam int COLOR_INDEX_W = 9;

   typedef struct packed {
      logic       first_of_image;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_payload_type;

   typedef struct packed {
      logic [COLOR_INDEX_W-1:0] color_index;
      logic                     is_new;
      logic                     palette_full;
   } rsp_payload_type;

   typedef struct packed {
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [COLOR_W-1:0] wr_data;
   } ram_req_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } pia_state_type;

endpackage
`default_nettype wire

>>> hdl/pia_palette_store.sv
// Palette color store: one write port, one registered read port.
// Depends on pia_pkg.
`default_nettype none
module pia_palette_store (
   input  wire                        clock,
   input  pia_pkg::ram_req_type       ram_req,
   output logic [pia_pkg::COLOR_W-1:0] rd_data
);
   import pia_pkg::*;

   logic [COLOR_W-1:0] mem [PALETTE_DEPTH];

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data <= mem[ram_req.rd_addr];
      end
   end

endmodule
`default_nettype wire

>>> hdl/pia_scan_seq.sv
// Scan sequencer: walks the stored palette with one shared comparator,
// appends unseen colors and forms the result. Depends on pia_pkg.
`default_nettype none
module pia_scan_seq (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  pia_pkg::req_payload_type     req_payload,
   output pia_pkg::ram_req_type         ram_req,
   input  wire [pia_pkg::COLOR_W-1:0]   rd_data,
   output logic                         res_valid,
   output pia_pkg::rsp_payload_type     res_payload,
   input  wire                          res_take
);
   import pia_pkg::*;

   pia_state_type   state_ff, state_in;
   logic [COLOR_W-1:0] rgb_ff, rgb_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic               pend_ff, pend_in;
   rsp_payload_type    res_ff, res_in;
   logic               hit;
   logic               last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rgb_ff <= rgb_in;
      ptr_ff <= ptr_in;
      res_ff <= res_in;
   end

   // pend_ff: rd_data holds entry ptr_ff-1 this cycle
   assign hit  = pend_ff && (rd_data == rgb_ff);
   assign last = (ptr_ff == count_ff);

   always_comb begin
      state_in         = state_ff;
      rgb_in           = rgb_ff;
      count_in         = count_ff;
      ptr_in           = ptr_ff;
      pend_in          = 1'b0;
      res_in           = res_ff;
      req_ready        = 1'b0;
      res_valid        = 1'b0;
      ram_req.rd_en    = 1'b0;
      ram_req.rd_addr  = ptr_ff[ADDR_W-1:0];
      ram_req.wr_en    = 1'b0;
      ram_req.wr_addr  = count_ff[ADDR_W-1:0];
      ram_req.wr_data  = rgb_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               rgb_in = {req_payload.red, req_payload.green, req_payload.blue};
               if (req_payload.first_of_image) begin
                  count_in = '0;
               end
               ptr_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               res_in.color_index  = COLOR_INDEX_W'(ptr_ff);
               res_in.is_new       = 1'b0;
               res_in.palette_full = 1'b0;
               state_in            = ST_FINISH;
            end else if (last) begin
               if (count_ff < CNT_W'(PALETTE_DEPTH)) begin
                  ram_req.wr_en       = 1'b1;
                  count_in            = count_ff + 1'b1;
                  res_in.color_index  = COLOR_INDEX_W'(count_ff + 1'b1);
                  res_in.is_new       = 1'b1;
                  res_in.palette_full = 1'b0;
               end else begin
                  res_in.color_index  = '0;
                  res_in.is_new       = 1'b0;
                  res_in.palette_full = 1'b1;
               end
               state_in = ST_FINISH;
            end else begin
               ram_req.rd_en = 1'b1;
               ptr_in        = ptr_ff + 1'b1;
               pend_in       = 1'b1;
            end
         end
         ST_FINISH: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign res_payload = res_ff;

endmodule
`default_nettype wire

>>> hdl/palette_index_assigner.sv
// Top level of the palette index assigner: scan sequencer, color store and
// result register. Depends on pia_pkg, pia_palette_store, pia_scan_seq.
//
// Usage:
//   Input channel req_*: one sampled RGB color per transaction, with
//   first_of_image set to empty the palette before the color is handled.
//   Result channel rsp_*: one transaction per input, carrying the palette
//   index (from 1), the new-color flag and the palette-full flag.
//   Scan: the stored colors are compared in order, all of them on a miss
//   (the palette counts from 0 after first_of_image) and up to the match on
//   a hit. The result register loads after the scan, once it is free, and
//   req_ready returns with that same clock edge. The single comparator reads
//   one stored color per cycle from the palette memory.
//   req_ready is high only between transactions.
//   Reset empties the palette (count to 0) and drops any pending result;
//   memory contents are not cleared and need no clearing pass.
//   Stall: a finished result waits in the output register until rsp_ready;
//   the next input may be accepted meanwhile, and its result is held in the
//   sequencer until the output register frees up.
`default_nettype none
module palette_index_assigner (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  pia_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output pia_pkg::rsp_payload_type  rsp_payload
);
   import pia_pkg::*;

   ram_req_type        ram_req;
   logic [COLOR_W-1:0] rd_data;
   logic               res_valid;
   rsp_payload_type    res_payload;
   logic               res_take;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;

   pia_palette_store u_store (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   pia_scan_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .ram_req     (ram_req),
      .rd_data     (rd_data),
      .res_valid   (res_valid),
      .res_payload (res_payload),
      .res_take    (res_take)
   );

   assign res_take = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (res_take) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_payload_in = res_payload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule
`default_nettype wire

>>> dv/tb_top.sv
// Testbench for palette_index_assigner: a directed table followed by random images, checked
// against a local palette predictor, with sender idling, receiver stalls and a long hold-off.
// Depends on pia_pkg and palette_index_assigner from hdl/.
module tb_top;
   import pia_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int DIRECTED_N = 16;

   typedef struct packed {
      logic            fixed;
      req_payload_type item;
      rsp_payload_type result;
   } stim_row_type;

   // Rows with fixed set carry a result that follows directly from the palette contents.
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_N] = '{
      '{1'b1, '{1'b0, 8'h00, 8'h00, 8'h00}, '{9'd1, 1'b1, 1'b0}},
      '{1'b1, '{1'b0, 8'hFF, 8'hFF, 8'hFF}, '{9'd2, 1'b1, 1'b0}},
      '{1'b1, '{1'b0, 8'h00, 8'h00, 8'h00}, '{9'd1, 1'b0, 1'b0}},
      '{1'b1, '{1'b0, 8'hFF, 8'hFF, 8'hFF}, '{9'd2, 1'b0, 1'b0}},
      '{1'b1, '{1'b1, 8'hFF, 8'hFF, 8'hFF}, '{9'd1, 1'b1, 1'b0}},
      '{1'b1, '{1'b0, 8'h00, 8'h00, 8'h00}, '{9'd2, 1'b1, 1'b0}},
      '{1'b0, '{1'b0, 8'hFF, 8'h00, 8'h00}, '{9'd0, 1'b0, 1'b0}},
      '{1'b0, '{1'b0, 8'h00, 8'hFF, 8'h00}, '{9'd0, 1'b0, 1'b0}},
      '{1'b0, '{1'b0, 8'h00, 8'h00, 8'hFF}, '{9'd0, 1'b0, 1'b0}},
      '{1'b0, '{1'b0, 8'hFF, 8'h00, 8'h00}, '{9'd0, 1'b0, 1'b0}},
      '{1'b1, '{1'b1, 8'h00, 8'h00, 8'h00}, '{9'd1, 1'b1, 1'b0}},
      '{1'b1, '{1'b1, 8'h00, 8'h00, 8'h00}, '{9'd1, 1'b1, 1'b0}},
      '{1'b0, '{1'b0, 8'h12, 8'h34, 8'h56}, '{9'd0, 1'b0, 1'b0}},
      '{1'b0, '{1'b0, 8'hAA, 8'h55, 8'hA5}, '{9'd0, 1'b0, 1'b0}},
      '{1'b0, '{1'b1, 8'h55, 8'hAA, 8'h5A}, '{9'd0, 1'b0, 1'b0}},
      '{1'b0, '{1'b0, 8'hAA, 8'h55, 8'hA5}, '{9'd0, 1'b0, 1'b0}}
   };

   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];
   int unsigned        palette_used = 0;
   rsp_payload_type    index_q [$];

   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_off_request = 1'b0;
   int  mismatch_count = 0;
   int  cycle_count = 0;

   palette_index_assigner i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_payload_type assign_index(input req_payload_type item);
      logic [COLOR_W-1:0] rgb;
      int unsigned        hit;
      rsp_payload_type    r;
      rgb = {item.red, item.green, item.blue};
      if (item.first_of_image) begin
         palette_used = 0;
      end
      hit = 0;
      for (int unsigned i = 0; i < palette_used; i++) begin
         if (hit == 0 && palette_mem[i] == rgb) begin
            hit = i + 1;
         end
      end
      r = '0;
      if (hit != 0) begin
         r.color_index = COLOR_INDEX_W'(hit);
      end else if (palette_used < PALETTE_DEPTH) begin
         palette_mem[palette_used] = rgb;
         palette_used++;
         r.color_index = COLOR_INDEX_W'(palette_used);
         r.is_new = 1'b1;
      end else begin
         r.palette_full = 1'b1;
      end
      return r;
   endfunction

   task automatic offer_color(input req_payload_type item, input logic fixed,
                              input rsp_payload_type fixed_rsp);
      rsp_payload_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      predicted = assign_index(item);
      index_q.insert(index_q.size(), fixed ? fixed_rsp : predicted);
   endtask

   // Short images over a small color pool, with the odd missing or stray image start.
   task automatic run_small_images(input int target);
      int                 sent;
      int                 len;
      int                 pool_n;
      logic [COLOR_W-1:0] pool [12];
      req_payload_type    item;
      sent = 0;
      while (sent < target) begin
         pool_n = $urandom_range(12, 1);
         for (int k = 0; k < pool_n; k++) begin
            if ($urandom_range(7) == 0) begin
               pool[k] = $urandom_range(1) ? {COLOR_W{1'b1}} : {COLOR_W{1'b0}};
            end else begin
               pool[k] = COLOR_W'($urandom);
            end
         end
         len = $urandom_range(25, 1);
         for (int k = 0; k < len; k++) begin
            item.first_of_image = (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
            {item.red, item.green, item.blue} = pool[$urandom_range(pool_n - 1)];
            offer_color(item, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // One long image with mostly fresh colors, enough to fill the palette and overflow it.
   task automatic run_large_image(input int len);
      logic [COLOR_W-1:0] pool [300];
      int                 fresh;
      req_payload_type    item;
      for (int k = 0; k < 300; k++) begin
         pool[k] = COLOR_W'($urandom);
      end
      fresh = 0;
      for (int k = 0; k < len; k++) begin
         item.first_of_image = (k == 0);
         if (fresh < 300 && $urandom_range(9) != 0) begin
            {item.red, item.green, item.blue} = pool[fresh];
            fresh++;
         end else begin
            {item.red, item.green, item.blue} = pool[$urandom_range(fresh == 0 ? 0 : fresh - 1)];
         end
         offer_color(item, 1'b0, '0);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < DIRECTED_N; i++) begin
         offer_color(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].result);
      end
      run_small_images(60);

      send_idle_pct  = 49;
      recv_stall_pct = 0;
      run_large_image(300);

      send_idle_pct    = 0;
      recv_stall_pct   = 49;
      hold_off_request = 1'b1;
      run_small_images(60);

      send_idle_pct  = 32;
      recv_stall_pct = 32;
      run_large_image(300);

      req_valid <= 1'b0;
      while (index_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && index_q.size() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   initial begin
      rsp_payload_type exp_rsp;
      int              hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (index_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("unexpected transaction: index %0d new %b full %b",
                           rsp_payload.color_index, rsp_payload.is_new,
                           rsp_payload.palette_full);
               end
            end else begin
               exp_rsp = index_q.pop_front();
               if (rsp_payload.color_index !== exp_rsp.color_index ||
                   rsp_payload.is_new !== exp_rsp.is_new ||
                   rsp_payload.palette_full !== exp_rsp.palette_full) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch: expected index %0d new %b full %b, got %0d %b %b",
                              exp_rsp.color_index, exp_rsp.is_new, exp_rsp.palette_full,
                              rsp_payload.color_index, rsp_payload.is_new,
                              rsp_payload.palette_full);
                  end
               end
            end
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_top: errors");
      $finish;
   end

endmodule
